// ===== sv/sine_degree_day_accumulator_macros.svh =====
// ----------------------------------------------------------------------------
// sine_degree_day_accumulator_macros
// assertion macros used by the degree-day accumulator top module
// ----------------------------------------------------------------------------
`ifndef SINE_DEGREE_DAY_ACCUMULATOR_MACROS_SVH
`define SINE_DEGREE_DAY_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define SDDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdda same-cycle check failed");

// next-cycle implication
`define SDDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdda next-cycle check failed");

`endif

// ===== sv/sdda_pkg.sv =====
// ----------------------------------------------------------------------------
// sdda_pkg
// types, constants and tables of the degree-day accumulator
// ----------------------------------------------------------------------------
package sdda_pkg;

  typedef struct packed {
    logic [3:0]          month_number;
    logic                leap_year;
    logic signed [15:0]  min_temp;
    logic signed [15:0]  max_temp;
    logic                year_end;
  } sdda_in_t;

  typedef struct packed {
    logic [20:0] month_gdd;
    logic [24:0] year_gdd;
    logic        year_done;
    logic        total_saturated;
  } sdda_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CLASS,
    ST_SQUARE,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_ANGLE,
    ST_PROD,
    ST_TERM,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN
  } sdda_state_t;

  localparam logic CFG_BASE_TEMP      = 1'b0;
  localparam logic CFG_EVERGREEN_MODE = 1'b1;

  localparam logic signed [15:0] BASE_TEMP_RESET = 16'sd1280;

  localparam int SQRT_STEPS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 25;

  localparam logic [17:0] PI_Q16     = 18'd205887;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [20:0] MONTH_MAX  = 21'h1FFFFF;
  localparam logic [24:0] TOTAL_MAX  = 25'h1FFFFFF;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_OCT = 4'd10;

  function automatic logic [15:0] atan_q16(input logic [3:0] idx);
    logic [15:0] val;
    unique case (idx)
      4'd0:    val = 16'd51472;
      4'd1:    val = 16'd30386;
      4'd2:    val = 16'd16055;
      4'd3:    val = 16'd8150;
      4'd4:    val = 16'd4091;
      4'd5:    val = 16'd2047;
      4'd6:    val = 16'd1024;
      4'd7:    val = 16'd512;
      4'd8:    val = 16'd256;
      4'd9:    val = 16'd128;
      4'd10:   val = 16'd64;
      4'd11:   val = 16'd32;
      4'd12:   val = 16'd16;
      4'd13:   val = 16'd8;
      4'd14:   val = 16'd4;
      default: val = 16'd2;
    endcase
    return val;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      MONTH_FEB:                                  d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/sdda_isqrt.sv =====
// ----------------------------------------------------------------------------
// sdda_isqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module sdda_isqrt
  import sdda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] rem;
  logic [31:0] r;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic        busy;
  logic [31:0] trial;

  assign trial = r + bitv;
  assign root  = r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      r    <= '0;
      bitv <= 32'h4000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== sv/sdda_cordic.sv =====
// ----------------------------------------------------------------------------
// sdda_cordic
// vectoring cordic, angle of (x, y) in q16 radians, one step per cycle
// ----------------------------------------------------------------------------
module sdda_cordic
  import sdda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        x_in,
  input  logic [15:0]        y_in,
  output logic               done,
  output logic signed [19:0] angle
);

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [19:0] z;
  logic [3:0]         idx;
  logic               busy;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [19:0] step;
  logic               ypos;

  assign xs    = x >>> idx;
  assign ys    = y >>> idx;
  assign step  = $signed({4'b0, atan_q16(idx)});
  assign ypos  = !y[32] && (y != '0);
  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 4'd1;
        if (idx == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= $signed({3'b0, x_in, 14'b0});
      y <= $signed({3'b0, y_in, 14'b0});
      z <= '0;
    end else if (busy) begin
      if (ypos) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step;
      end
    end
  end

endmodule

// ===== sv/sdda_div.sv =====
// ----------------------------------------------------------------------------
// sdda_div
// restoring division by two pi in q16, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdda_div
  import sdda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [42:0] dividend,
  output logic        done,
  output logic [24:0] quotient
);

  logic [42:0] rem;
  logic [42:0] dsh;
  logic [4:0]  cnt;
  logic        busy;
  logic        ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= 43'(TWO_PI_Q16) << (DIV_STEPS - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[23:0], ge};
      dsh      <= dsh >> 1;
    end
  end

endmodule

// ===== sv/sine_degree_day_accumulator.sv =====
// ----------------------------------------------------------------------------
// sine_degree_day_accumulator
// monthly single-sine degree days and a saturating yearly total
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | in_data (sdda_in_t)
//   out     | output    | out_valid / out_stall  | out_data (sdda_out_t)
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a month that is not counted, fully above or below the base or flat goes from the
// class state straight to the final state; a partly covered month runs the square
// root (16 steps), cordic (16 steps) and, for a positive integrand, the divide by
// two pi (25 steps), each one step per cycle; a stalled result holds the month in
// the final state; one month is in work at a time; the next is taken while a result
// waits; reset (rst, synchronous) clears the total and loads the register defaults
// ----------------------------------------------------------------------------
module sine_degree_day_accumulator
  import sdda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sdda_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output sdda_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  `include "sine_degree_day_accumulator_macros.svh"

  sdda_state_t state;
  sdda_state_t state_next;

  logic signed [15:0] base_temp;
  logic               evergreen_mode;
  logic [24:0]        running_total;

  sdda_in_t           item;
  logic [4:0]         days;
  logic               counted;
  logic               full;
  logic               below;
  logic               a2pos;
  logic [15:0]        a2;
  logic signed [16:0] u2;
  logic signed [17:0] xfull;
  logic [31:0]        asq;
  logic [31:0]        usq;
  logic signed [19:0] phi;
  logic signed [36:0] prod;
  logic               tpos;
  logic [42:0]        tdays;
  logic [20:0]        g;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic               sqrt_start;
  logic               div_start;
  logic               cordic_start;
  logic               sqrt_done;
  logic               cordic_done;
  logic               div_done;
  logic [15:0]        s2;
  logic signed [19:0] angle;
  logic [24:0]        quotient;

  logic signed [16:0] sum2;
  logic signed [16:0] b2;
  logic signed [16:0] diff;
  logic signed [17:0] u2raw;
  logic signed [17:0] u2c;
  logic [4:0]         days_c;
  logic               counted_c;
  logic [21:0]        fprod;
  logic [21:0]        fround;
  logic [15:0]        uabs;
  logic signed [37:0] t;
  logic [25:0]        sum;
  logic               sat;
  logic [24:0]        total_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_temp      <= BASE_TEMP_RESET;
      evergreen_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_TEMP:      base_temp      <= $signed(cfg_data);
        CFG_EVERGREEN_MODE: evergreen_mode <= cfg_data[0];
      endcase
    end
  end

  // classification, term and total arithmetic
  always_comb begin
    sum2      = 17'(item.min_temp) + 17'(item.max_temp);
    b2        = $signed({base_temp, 1'b0});
    diff      = 17'(item.max_temp) - 17'(item.min_temp);
    u2raw     = 18'(b2) - 18'(sum2);
    priority if (u2raw > 18'(diff)) begin
      u2c = 18'(diff);
    end else if (u2raw < -18'(diff)) begin
      u2c = -18'(diff);
    end else begin
      u2c = u2raw;
    end
    days_c    = month_days(item.month_number, item.leap_year);
    counted_c = (days_c != '0) && (evergreen_mode ||
                (item.month_number >= MONTH_APR && item.month_number <= MONTH_OCT));
    fprod     = 22'(xfull[16:0]) * 22'(days);
    fround    = 22'((23'(fprod) + 23'd1) >> 1);
    uabs      = u2[16] ? 16'(-u2) : u2[15:0];
    t         = $signed({6'b0, s2, 16'b0}) - 38'(prod);
    sum       = 26'(running_total) + 26'(g);
    sat       = sum >= 26'(TOTAL_MAX);
    total_new = sat ? TOTAL_MAX : sum[24:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_PREP;
      ST_PREP:      state_next = ST_CLASS;
      ST_CLASS: begin
        if (!counted || full || below || !a2pos) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE:    state_next = ST_ROOT;
      ST_ROOT:      state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (sqrt_done) state_next = ST_ANGLE;
      ST_ANGLE:     if (cordic_done) state_next = ST_PROD;
      ST_PROD:      state_next = ST_TERM;
      ST_TERM:      state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = tpos ? ST_DIV : ST_FIN;
      ST_DIV:       if (div_done) state_next = ST_FIN;
      ST_FIN:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sqrt_start   = (state == ST_ROOT);
    cordic_start = (state == ST_ROOT_WAIT) && sqrt_done;
    div_start    = (state == ST_DIV_GO) && tpos;
    load_out     = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    unique case (state)
      ST_PREP: begin
        days    <= days_c;
        counted <= counted_c;
        full    <= item.min_temp >= base_temp;
        below   <= item.max_temp < base_temp;
        a2pos   <= !diff[16] && (diff != '0);
        a2      <= diff[15:0];
        u2      <= u2c[16:0];
        xfull   <= 18'(sum2) - 18'(b2);
      end
      ST_CLASS: begin
        if (counted && full && !xfull[17] && (xfull != '0)) begin
          g <= (fround > 22'(MONTH_MAX)) ? MONTH_MAX : fround[20:0];
        end else begin
          g <= '0;
        end
      end
      ST_SQUARE: begin
        asq <= 32'(a2) * 32'(a2);
        usq <= 32'(uabs) * 32'(uabs);
      end
      ST_ANGLE: begin
        if (cordic_done) begin
          phi <= u2[16] ? ($signed(20'(PI_Q16)) - angle) : angle;
        end
      end
      ST_PROD: begin
        prod <= 37'(u2) * 37'(phi);
      end
      ST_TERM: begin
        tpos  <= !t[37] && (t != '0);
        tdays <= 43'(t[36:0]) * 43'(days) + 43'(PI_Q16);
      end
      ST_DIV: begin
        if (div_done) begin
          g <= (quotient > 25'(MONTH_MAX)) ? MONTH_MAX : quotient[20:0];
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_data <= '{month_gdd: g, year_gdd: total_new, year_done: item.year_end,
                    total_saturated: sat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      running_total <= '0;
    end else begin
      if (load_out) begin
        out_valid     <= 1'b1;
        running_total <= item.year_end ? '0 : total_new;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  sdda_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (asq - usq),
    .done     (sqrt_done),
    .root     (s2)
  );

  sdda_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (uabs),
    .y_in  (s2),
    .done  (cordic_done),
    .angle (angle)
  );

  sdda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tdays),
    .done     (div_done),
    .quotient (quotient)
  );

  `SDDA_ASSERT_IMP(a_year_ge_month, out_valid, out_data.year_gdd >= 25'(out_data.month_gdd))
  `SDDA_ASSERT_IMP(a_sat_at_max, out_valid && out_data.total_saturated, out_data.year_gdd == TOTAL_MAX)
  `SDDA_ASSERT_NXT(a_year_clear, load_out && item.year_end, running_total == '0)
  `SDDA_ASSERT_IMP(a_uncounted_zero, (state == ST_FIN) && !counted, g == '0)

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// monthly sine degree-day accumulator: directed table plus random months,
// checked field by field against set values or a bench model of the block
// ----------------------------------------------------------------------------
module tb_top;
  import sdda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  sdda_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  sdda_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  sine_degree_day_accumulator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    sdda_in_t  month_rec;
    logic      has_gold;
    sdda_out_t gold;
  } dir_row_t;

  localparam int RANDOM_MONTHS = 1330;

  sdda_out_t   gdd_expected_q[$];
  int          error_count;
  int          months_sent;
  int          results_seen;
  int          partial_months;
  int          saturated_seen;
  bit          stim_done;
  bit          long_hold;
  logic signed [15:0] base_shadow;
  logic        evergreen_shadow;
  logic [24:0] total_shadow;
  dir_row_t    dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic longint shift_floor(input longint v, input int s);
    return (v >= 0) ? (v >>> s) : ~((~v) >>> s);
  endfunction

  function automatic longint int_root(input longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - r - b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_phase(input longint x, input longint y);
    longint z, xs, ys;
    longint arc[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
    z = 0;
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < 16; i++) begin
      xs = shift_floor(x, i);
      ys = shift_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arc[i];
      end else begin
        x -= ys; y += xs; z -= arc[i];
      end
    end
    return z;
  endfunction

  function automatic longint sine_month_gdd(input longint tmin, input longint tmax,
                                            input longint base, input longint days);
    longint g, x, a2, u2, s2, phi, t;
    if (tmin >= base) begin
      x = tmax + tmin - 2 * base;
      if (x <= 0) return 0;
      g = (x * days + 1) >>> 1;
    end else if (tmax < base) begin
      return 0;
    end else begin
      a2 = tmax - tmin;
      if (a2 <= 0) return 0;
      partial_months++;
      u2 = 2 * base - (tmax + tmin);
      if (u2 > a2) u2 = a2;
      if (u2 < -a2) u2 = -a2;
      s2 = int_root(a2 * a2 - u2 * u2);
      if (u2 >= 0) phi = cordic_phase(u2, s2);
      else phi = 205887 - cordic_phase(-u2, s2);
      t = s2 * 65536 - u2 * phi;
      if (t <= 0) return 0;
      g = (t * days + 205887) / 411775;
    end
    return (g > 2097151) ? 2097151 : g;
  endfunction

  function automatic sdda_out_t predict_month(input sdda_in_t m);
    sdda_out_t r;
    int        days;
    longint    g, sum;
    days = 0;
    case (m.month_number)
      1, 3, 5, 7, 8, 10, 12: days = 31;
      4, 6, 9, 11:           days = 30;
      2:                     days = m.leap_year ? 29 : 28;
      default:               days = 0;
    endcase
    g = 0;
    if (days != 0 && (evergreen_shadow || (m.month_number >= 4 && m.month_number <= 10)))
      g = sine_month_gdd(m.min_temp, m.max_temp, base_shadow, days);
    sum = longint'(total_shadow) + g;
    r.total_saturated = 1'b0;
    if (sum >= 33554431) begin
      sum = 33554431;
      r.total_saturated = 1'b1;
    end
    r.month_gdd = g[20:0];
    r.year_gdd  = sum[24:0];
    r.year_done = m.year_end;
    total_shadow = m.year_end ? 25'd0 : sum[24:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rand_temp();
    case ($urandom_range(0, 5))
      0:       return 16'(-25600 + $urandom_range(0, 51200));
      1:       return 16'sd25600 - 16'($urandom_range(0, 64));
      2:       return -16'sd25600 + 16'($urandom_range(0, 64));
      default: return 16'(base_shadow + $signed(17'($urandom_range(0, 6000))) - 17'sd3000);
    endcase
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BASE_TEMP) base_shadow = val;
    else evergreen_shadow = val[0];
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (gdd_expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic send_month(input sdda_in_t m, input bit hurry);
    int gap;
    sdda_out_t p;
    gap = hurry ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (in_stall);
    p = predict_month(m);
    gdd_expected_q.insert(gdd_expected_q.size(), p);
    months_sent++;
  endtask

  task automatic add_row(input logic [3:0] mo, input logic lp, input int lo, input int hi,
                         input logic ye, input logic has, input int mg, input int yg,
                         input logic sat);
    dir_row_t row;
    row.month_rec = '{month_number: mo, leap_year: lp, min_temp: 16'(lo),
                      max_temp: 16'(hi), year_end: ye};
    row.has_gold = has;
    row.gold = '{month_gdd: 21'(mg), year_gdd: 25'(yg), year_done: ye,
                 total_saturated: sat};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  always @(posedge clk) begin
    sdda_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (gdd_expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_data.year_gdd, -1);
      end else begin
        want = gdd_expected_q.pop_front();
        if (out_data.total_saturated) saturated_seen++;
        if (out_data.month_gdd !== want.month_gdd)
          report_mismatch("month_gdd", out_data.month_gdd, want.month_gdd);
        if (out_data.year_gdd !== want.year_gdd)
          report_mismatch("year_gdd", out_data.year_gdd, want.year_gdd);
        if (out_data.year_done !== want.year_done)
          report_mismatch("year_done", out_data.year_done, want.year_done);
        if (out_data.total_saturated !== want.total_saturated)
          report_mismatch("total_saturated", out_data.total_saturated, want.total_saturated);
      end
    end
  end

  // output back-pressure, with one long hold while the sender keeps going
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (months_sent > 600 && months_sent < 700) hold = 0;
      out_stall <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin
    sdda_in_t m;
    sdda_out_t p;
    int guard;
    int gap;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BASE_TEMP;
    cfg_data = '0;
    error_count = 0;
    months_sent = 0;
    results_seen = 0;
    partial_months = 0;
    saturated_seen = 0;
    long_hold = 1'b0;
    base_shadow = BASE_TEMP_RESET;
    evergreen_shadow = 1'b0;
    total_shadow = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // after reset: base 5.0 C, deciduous window
    add_row(4'd1, 0, 5120, 7680, 0, 1, 0, 0, 0);
    add_row(4'd4, 0, 2560, 7680, 0, 1, 115200, 115200, 0);
    add_row(4'd5, 0, -25600, 1024, 0, 1, 0, 115200, 0);
    add_row(4'd6, 0, 25600, 25600, 0, 1, 729600, 844800, 0);
    add_row(4'd0, 1, 25600, 25600, 0, 1, 0, 844800, 0);
    add_row(4'd15, 0, 25600, 25600, 1, 1, 0, 844800, 0);
    add_row(4'd7, 0, -25600, 25600, 0, 0, 0, 0, 0);
    add_row(4'd8, 0, 0, 2560, 0, 0, 0, 0, 0);
    add_row(4'd9, 0, 1000, 1000, 0, 0, 0, 0, 0);
    add_row(4'd10, 0, 2000, 1000, 0, 0, 0, 0, 0);
    add_row(4'd11, 0, 25600, 25600, 0, 0, 0, 0, 0);
    add_row(4'd3, 1, -256, 1280, 1, 0, 0, 0, 0);
    foreach (dir_rows[i]) begin
      p = predict_month(dir_rows[i].month_rec);
      gdd_expected_q.insert(gdd_expected_q.size(),
                            dir_rows[i].has_gold ? dir_rows[i].gold : p);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= dir_rows[i].month_rec;
      do @(posedge clk); while (in_stall);
      months_sent++;
    end
    drain_results();

    // evergreen, lowest base: saturates the total
    write_reg(CFG_EVERGREEN_MODE, 16'd1);
    write_reg(CFG_BASE_TEMP, -16'sd25600);
    for (int i = 0; i < 24; i++) begin
      m = '{month_number: 4'(i % 12 + 1), leap_year: 1'b1, min_temp: 16'sd25600,
            max_temp: 16'sd25600, year_end: 1'b0};
      send_month(m, 0);
    end
    m.month_number = 4'd2; m.leap_year = 1'b0; m.year_end = 1'b1;
    send_month(m, 0);
    drain_results();
    write_reg(CFG_BASE_TEMP, 16'sd25600);
    m.month_number = 4'd2; m.leap_year = 1'b1; m.min_temp = -16'sd25600; m.year_end = 1'b1;
    send_month(m, 0);
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(CFG_EVERGREEN_MODE, 16'($urandom_range(0, 1)));
      write_reg(CFG_BASE_TEMP, 16'(-3000 + $urandom_range(0, 9000)));
      if (phase == 4) write_reg(CFG_BASE_TEMP, 16'($urandom_range(0, 65535)));
      for (int k = 0; k < RANDOM_MONTHS / 5; k++) begin
        if (phase == 2 && k == 20) long_hold = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          m = sdda_in_t'(38'({$urandom(), $urandom()}));
        end else begin
          m.month_number = 4'(k % 12 + 1);
          m.leap_year = 1'($urandom());
          m.min_temp = rand_temp();
          m.max_temp = ($urandom_range(0, 7) == 0) ? rand_temp()
                     : 16'(m.min_temp + 16'($urandom_range(0, 5000)));
          m.year_end = (k % 12 == 11) || ($urandom_range(0, 60) == 0);
        end
        send_month(m, phase == 2 && k >= 20 && k < 60);
      end
      drain_results();
    end

    guard = 0;
    while (gdd_expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    $display("covered %0d months, %0d results, %0d partly above base, %0d saturated totals",
             months_sent, results_seen, partial_months, saturated_seen);
    $display("register settings included both modes and both base extremes");
    if (error_count == 0 && gdd_expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (gdd_expected_q.size() != 0) report_mismatch("missing transactions",
                                                      gdd_expected_q.size(), 0);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/sdda_pkg.sv
sv/sdda_isqrt.sv
sv/sdda_cordic.sv
sv/sdda_div.sv
sv/sine_degree_day_accumulator.sv
sim/tb_top.sv
